// ----- design/esc_pkg.sv -----
// Shared types and constants for the environment sensor compensation block.
// No dependencies; every other design file imports this package.
package esc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM        = 3'd4;

    // Result limits
    localparam logic [24:0] PRESS_MAX = 25'h1FFFFFF;
    localparam logic [16:0] HUM_MAX   = 17'd102400;

    // Input transaction
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    // Output transaction
    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [24:0]        pressure_q24_8;
        logic               pressure_invalid;
        logic [16:0]        humidity_q22_10;
    } result_t;

    // Decoded calibration coefficients
    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } calib_t;

endpackage

// ----- design/esc_front.sv -----
// Front end: accepts input transactions into a two-entry queue.
// Depends on esc_pkg.
module esc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  esc_pkg::sample_t sample,
    output logic             item_valid,
    input  logic             item_ready,
    output esc_pkg::sample_t item
);
    import esc_pkg::*;

    sample_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign sample_ready = (count_reg != 2'd2);
    assign item_valid   = (count_reg != 2'd0);
    assign item         = mem_reg[rd_ptr_reg];
    assign push         = sample_valid && sample_ready;
    assign pop          = item_valid && item_ready;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= sample;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- design/esc_mul.sv -----
// Sequential multiplier: low 64 bits of a 64x64 product, 16 bits per cycle.
// Depends on esc_pkg.
module esc_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);
    import esc_pkg::*;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [79:0] pp;

    assign pp      = a_reg * b_reg[15:0];
    assign done    = done_reg;
    assign product = acc_reg;

    // Operand shift and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << 16;
            b_reg   <= b_reg >> 16;
            acc_reg <= acc_reg + pp[63:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- design/esc_div.sv -----
// Restoring signed divider, 64 bits, one quotient bit per cycle, truncating.
// Depends on esc_pkg.
module esc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import esc_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dv_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] rem_sh;
    logic [64:0] diff;

    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign diff     = rem_sh - {1'b0, dv_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;

    // Datapath on magnitudes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[63] ^ divisor[63];
            quo_reg <= dividend[63] ? (64'd0 - dividend) : dividend;
            dv_reg  <= divisor[63] ? (64'd0 - divisor) : divisor;
            rem_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[64] ? rem_sh[63:0] : diff[63:0];
            quo_reg <= {quo_reg[62:0], ~diff[64]};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- design/esc_back.sv -----
// Back end: sequences the compensation formulas over the shared multiplier
// and divider and holds the result register. Depends on esc_pkg, esc_mul, esc_div.
module esc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  esc_pkg::calib_t  calib,
    input  logic             item_valid,
    output logic             item_ready,
    input  esc_pkg::sample_t item,
    output logic             result_valid,
    input  logic             result_ready,
    output esc_pkg::result_t result
);
    import esc_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ISSUE = 5'b00010,
        PH_MUL   = 5'b00100,
        PH_DIV   = 5'b01000,
        PH_HOLD  = 5'b10000
    } phase_t;

    typedef enum logic [21:0] {
        S_T0 = 22'h000001, S_T1 = 22'h000002, S_T2 = 22'h000004, S_T3 = 22'h000008,
        S_P0 = 22'h000010, S_P1 = 22'h000020, S_P2 = 22'h000040, S_P3 = 22'h000080,
        S_P4 = 22'h000100, S_P5 = 22'h000200, S_P6 = 22'h000400, S_P7 = 22'h000800,
        S_P8 = 22'h001000, S_P9 = 22'h002000, S_H0 = 22'h004000, S_H1 = 22'h008000,
        S_H2 = 22'h010000, S_H3 = 22'h020000, S_H4 = 22'h040000, S_H5 = 22'h080000,
        S_H6 = 22'h100000, S_H7 = 22'h200000
    } step_t;

    localparam logic [63:0] HUM_CLAMP = 64'd419430400;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    phase_t      phase_reg, phase_next;
    step_t       step_reg, step_next;
    sample_t     it_reg, it_next;
    logic [31:0] tv_reg, tv_next;
    logic [31:0] tf_reg, tf_next;
    logic [63:0] sq_reg, sq_next;
    logic [63:0] pv2_reg, pv2_next;
    logic [63:0] pa_reg, pa_next;
    logic [63:0] dv_reg, dv_next;
    logic [63:0] p_reg, p_next;
    logic [31:0] ha_reg, ha_next;
    logic [31:0] hb_reg, hb_next;
    logic [31:0] hc_reg, hc_next;
    logic [31:0] hd_reg, hd_next;
    logic [31:0] he_reg, he_next;
    logic [31:0] hx_reg, hx_next;
    logic [15:0] t_out_reg, t_out_next;
    logic [24:0] p_out_reg, p_out_next;
    logic        inv_reg, inv_next;
    logic [16:0] h_out_reg, h_out_next;
    result_t     res_reg, res_next;
    logic        res_valid_reg, res_valid_next;

    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] m;
    logic        div_start;
    logic        div_done;
    logic [63:0] quo;
    logic [63:0] pv1;
    logic [31:0] hxt;

    assign item_ready   = (phase_reg == PH_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign mul_start    = (phase_reg == PH_ISSUE);
    assign div_start    = (phase_reg == PH_MUL) && mul_done && (step_reg == S_P6);
    assign pv1          = sx32(tf_reg) - 64'd128000;
    assign hxt          = tf_reg - 32'd76800;

    esc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (m)
    );

    esc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (m),
        .divisor  (dv_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Operand selection per step
    always_comb
    begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        case (step_reg)
            S_T0:
            begin
                mul_a = 64'(it_reg.raw_temperature >> 3) - (64'(calib.t1) << 1);
                mul_b = 64'(calib.t2);
            end
            S_T1:
            begin
                mul_a = 64'(it_reg.raw_temperature >> 4) - 64'(calib.t1);
                mul_b = mul_a;
            end
            S_T2:
            begin
                mul_a = sx32(ha_reg);
                mul_b = 64'(calib.t3);
            end
            S_T3:
            begin
                mul_a = sx32(tf_reg);
                mul_b = 64'd5;
            end
            S_P0:
            begin
                mul_a = pv1;
                mul_b = pv1;
            end
            S_P1:
            begin
                mul_a = sq_reg;
                mul_b = 64'(calib.p6);
            end
            S_P2:
            begin
                mul_a = pv1;
                mul_b = 64'(calib.p5);
            end
            S_P3:
            begin
                mul_a = sq_reg;
                mul_b = 64'(calib.p3);
            end
            S_P4:
            begin
                mul_a = pv1;
                mul_b = 64'(calib.p2);
            end
            S_P5:
            begin
                mul_a = (64'd1 << 47) + pa_reg;
                mul_b = 64'(calib.p1);
            end
            S_P6:
            begin
                mul_a = ((64'd1048576 - 64'(it_reg.raw_pressure)) << 31) - pv2_reg;
                mul_b = 64'd3125;
            end
            S_P7:
            begin
                mul_a = 64'(calib.p9);
                mul_b = pa_reg;
            end
            S_P8:
            begin
                mul_a = sq_reg;
                mul_b = pa_reg;
            end
            S_P9:
            begin
                mul_a = 64'(calib.p8);
                mul_b = p_reg;
            end
            S_H0:
            begin
                mul_a = 64'(calib.h5);
                mul_b = sx32(hxt);
            end
            S_H1:
            begin
                mul_a = sx32(hxt);
                mul_b = 64'(calib.h6);
            end
            S_H2:
            begin
                mul_a = sx32(hxt);
                mul_b = 64'(calib.h3);
            end
            S_H3:
            begin
                mul_a = sx32(hb_reg);
                mul_b = sx32(hc_reg);
            end
            S_H4:
            begin
                mul_a = sx32(hd_reg);
                mul_b = 64'(calib.h2);
            end
            S_H5:
            begin
                mul_a = sx32(ha_reg);
                mul_b = sx32(he_reg);
            end
            S_H6:
            begin
                mul_a = sx32(hb_reg);
                mul_b = sx32(hb_reg);
            end
            S_H7:
            begin
                mul_a = sx32(hc_reg);
                mul_b = 64'(calib.h1);
            end
            default:
            begin
                mul_a = 64'd0;
                mul_b = 64'd0;
            end
        endcase
    end

    // Sequencer and post-processing of each product
    always_comb
    begin
        logic [31:0] w32;
        logic [63:0] w64;
        logic [63:0] v64;

        phase_next     = phase_reg;
        step_next      = step_reg;
        it_next        = it_reg;
        tv_next        = tv_reg;
        tf_next        = tf_reg;
        sq_next        = sq_reg;
        pv2_next       = pv2_reg;
        pa_next        = pa_reg;
        dv_next        = dv_reg;
        p_next         = p_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        hc_next        = hc_reg;
        hd_next        = hd_reg;
        he_next        = he_reg;
        hx_next        = hx_reg;
        t_out_next     = t_out_reg;
        p_out_next     = p_out_reg;
        inv_next       = inv_reg;
        h_out_next     = h_out_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        w32            = 32'd0;
        w64            = 64'd0;
        v64            = 64'd0;

        if (result_valid && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (item_valid)
                begin
                    it_next    = item;
                    inv_next   = 1'b0;
                    step_next  = S_T0;
                    phase_next = PH_ISSUE;
                end
            end
            PH_ISSUE:
            begin
                phase_next = PH_MUL;
            end
            PH_MUL:
            begin
                if (mul_done)
                begin
                    phase_next = PH_ISSUE;
                    case (step_reg)
                        S_T0:
                        begin
                            tv_next   = 32'($signed(m[31:0]) >>> 11);
                            step_next = S_T1;
                        end
                        S_T1:
                        begin
                            ha_next   = 32'($signed(m[31:0]) >>> 12);
                            step_next = S_T2;
                        end
                        S_T2:
                        begin
                            tf_next   = tv_reg + 32'($signed(m[31:0]) >>> 14);
                            step_next = S_T3;
                        end
                        S_T3:
                        begin
                            w32 = m[31:0] + 32'd128;
                            w32 = 32'($signed(w32) >>> 8);
                            if ($signed(w32) > 32'sd32767)
                            begin
                                t_out_next = 16'h7FFF;
                            end
                            else if ($signed(w32) < -32'sd32768)
                            begin
                                t_out_next = 16'h8000;
                            end
                            else
                            begin
                                t_out_next = w32[15:0];
                            end
                            step_next = S_P0;
                        end
                        S_P0:
                        begin
                            sq_next   = m;
                            step_next = S_P1;
                        end
                        S_P1:
                        begin
                            pv2_next  = m;
                            step_next = S_P2;
                        end
                        S_P2:
                        begin
                            pv2_next  = pv2_reg + (m << 17) + (64'(calib.p4) << 35);
                            step_next = S_P3;
                        end
                        S_P3:
                        begin
                            pa_next   = 64'($signed(m) >>> 8);
                            step_next = S_P4;
                        end
                        S_P4:
                        begin
                            pa_next   = pa_reg + (m << 12);
                            step_next = S_P5;
                        end
                        S_P5:
                        begin
                            w64     = 64'($signed(m) >>> 33);
                            dv_next = w64;
                            if (w64 == 64'd0)
                            begin
                                inv_next   = 1'b1;
                                p_out_next = 25'd0;
                                step_next  = S_H0;
                            end
                            else
                            begin
                                step_next = S_P6;
                            end
                        end
                        S_P6:
                        begin
                            // divider started on the same edge
                            phase_next = PH_DIV;
                            step_next  = S_P7;
                        end
                        S_P7:
                        begin
                            sq_next   = m;
                            step_next = S_P8;
                        end
                        S_P8:
                        begin
                            pv2_next  = 64'($signed(m) >>> 25);
                            step_next = S_P9;
                        end
                        S_P9:
                        begin
                            v64 = 64'($signed(m) >>> 19);
                            w64 = p_reg + pv2_reg + v64;
                            w64 = 64'($signed(w64) >>> 8) + (64'(calib.p7) << 4);
                            if (w64[63])
                            begin
                                p_out_next = 25'd0;
                            end
                            else if (w64 > 64'(PRESS_MAX))
                            begin
                                p_out_next = PRESS_MAX;
                            end
                            else
                            begin
                                p_out_next = w64[24:0];
                            end
                            step_next = S_H0;
                        end
                        S_H0:
                        begin
                            w32 = (32'(it_reg.raw_humidity) << 14)
                                - (32'(calib.h4) << 20) - m[31:0];
                            w32 = w32 + 32'd16384;
                            ha_next   = 32'($signed(w32) >>> 15);
                            step_next = S_H1;
                        end
                        S_H1:
                        begin
                            hb_next   = 32'($signed(m[31:0]) >>> 10);
                            step_next = S_H2;
                        end
                        S_H2:
                        begin
                            hc_next   = 32'($signed(m[31:0]) >>> 11) + 32'd32768;
                            step_next = S_H3;
                        end
                        S_H3:
                        begin
                            hd_next   = 32'($signed(m[31:0]) >>> 10) + 32'd2097152;
                            step_next = S_H4;
                        end
                        S_H4:
                        begin
                            w32       = m[31:0] + 32'd8192;
                            he_next   = 32'($signed(w32) >>> 14);
                            step_next = S_H5;
                        end
                        S_H5:
                        begin
                            hx_next   = m[31:0];
                            hb_next   = 32'($signed(m[31:0]) >>> 15);
                            step_next = S_H6;
                        end
                        S_H6:
                        begin
                            hc_next   = 32'($signed(m[31:0]) >>> 7);
                            step_next = S_H7;
                        end
                        S_H7:
                        begin
                            w32 = hx_reg - 32'($signed(m[31:0]) >>> 4);
                            if (w32[31])
                            begin
                                h_out_next = 17'd0;
                            end
                            else if (64'(w32) > HUM_CLAMP)
                            begin
                                h_out_next = HUM_MAX;
                            end
                            else
                            begin
                                h_out_next = w32[28:12];
                            end
                            phase_next = PH_HOLD;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_DIV:
            begin
                if (div_done)
                begin
                    p_next     = quo;
                    pa_next    = 64'($signed(quo) >>> 13);
                    phase_next = PH_ISSUE;
                end
            end
            PH_HOLD:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next.temperature_centi = t_out_reg;
                    res_next.pressure_q24_8    = p_out_reg;
                    res_next.pressure_invalid  = inv_reg;
                    res_next.humidity_q22_10   = h_out_reg;
                    res_valid_next             = 1'b1;
                    phase_next                 = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        it_reg    <= it_next;
        tv_reg    <= tv_next;
        tf_reg    <= tf_next;
        sq_reg    <= sq_next;
        pv2_reg   <= pv2_next;
        pa_reg    <= pa_next;
        dv_reg    <= dv_next;
        p_reg     <= p_next;
        ha_reg    <= ha_next;
        hb_reg    <= hb_next;
        hc_reg    <= hc_next;
        hd_reg    <= hd_next;
        he_reg    <= he_next;
        hx_reg    <= hx_next;
        t_out_reg <= t_out_next;
        p_out_reg <= p_out_next;
        inv_reg   <= inv_next;
        h_out_reg <= h_out_next;
        res_reg   <= res_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= S_T0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ----- design/environment_sensor_compensation.sv -----
// Environment sensor compensation block: top level with configuration registers.
// Depends on esc_pkg, esc_front, esc_back.
//
// Usage:
//  - sample channel (sample_valid/sample_ready/sample) takes one raw temperature,
//    pressure and humidity reading per transaction into a two-entry queue.
//  - result channel (result_valid/result_ready/result) returns one compensated
//    transaction per sample, in order.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the calibration
//    words; cfg_ready is always high, unknown indexes are ignored. Write only
//    while no sample is in flight.
//  - Each sample takes 22 products on a 16-bit-per-cycle multiplier plus one
//    division in the bit-serial 64-bit divider (18 products and no division when
//    the pressure divisor is zero). The back end, sharing the multiplier and
//    divider, takes no new sample until it has finished the last one.
//  - Reset clears the queue, sequencer and result valid and all calibration
//    words to zero.
//  - A stalled receiver holds the result register; the back end then waits with
//    its next result finished and the queue keeps accepting up to two samples.
module environment_sensor_compensation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  esc_pkg::sample_t                 sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output esc_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data
);
    import esc_pkg::*;

    logic [47:0] temp_calib_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;
    logic [63:0] hum_calib_reg;
    calib_t      calib;
    logic        item_valid;
    logic        item_ready;
    sample_t     item;

    assign cfg_ready = 1'b1;

    // Calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= 48'd0;
            press_lo_reg   <= 64'd0;
            press_hi_reg   <= 64'd0;
            press_last_reg <= 16'd0;
            hum_calib_reg  <= 64'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TEMP:       temp_calib_reg <= cfg_data[47:0];
                CFG_PRESS_LO:   press_lo_reg   <= cfg_data;
                CFG_PRESS_HI:   press_hi_reg   <= cfg_data;
                CFG_PRESS_LAST: press_last_reg <= cfg_data[15:0];
                CFG_HUM:        hum_calib_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Coefficient decode
    always_comb
    begin
        calib.t1 = temp_calib_reg[15:0];
        calib.t2 = temp_calib_reg[31:16];
        calib.t3 = temp_calib_reg[47:32];
        calib.p1 = press_lo_reg[15:0];
        calib.p2 = press_lo_reg[31:16];
        calib.p3 = press_lo_reg[47:32];
        calib.p4 = press_lo_reg[63:48];
        calib.p5 = press_hi_reg[15:0];
        calib.p6 = press_hi_reg[31:16];
        calib.p7 = press_hi_reg[47:32];
        calib.p8 = press_hi_reg[63:48];
        calib.p9 = press_last_reg;
        calib.h1 = hum_calib_reg[7:0];
        calib.h2 = hum_calib_reg[23:8];
        calib.h3 = hum_calib_reg[31:24];
        calib.h4 = hum_calib_reg[43:32];
        calib.h5 = hum_calib_reg[55:44];
        calib.h6 = hum_calib_reg[63:56];
    end

    esc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item)
    );

    esc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .calib        (calib),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    // A zero divisor always forces the pressure to zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pressure_invalid |-> result.pressure_q24_8 == 25'd0)
        else $error("pressure not zero with invalid flag");

    // Humidity never exceeds the clamp
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.humidity_q22_10 <= HUM_MAX)
        else $error("humidity above clamp");
`endif

endmodule
